@@ src/dmpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmpr_pkg: shared types, codes and scaling functions
// Request and register codes, per-channel operation codes, channel views and
// the constant-divisor conversions between percent and 0..255 speed.
// ----------------------------------------------------------------------------
package dmpr_pkg;

    // request kinds (tuser on the slave side)
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_LEFT_PCT  = 3'd1;
    localparam logic [2:0] REQ_RIGHT_PCT = 3'd2;
    localparam logic [2:0] REQ_LEFT_RAW  = 3'd3;
    localparam logic [2:0] REQ_RIGHT_RAW = 3'd4;
    localparam logic [2:0] REQ_LEFT_DIR  = 3'd5;
    localparam logic [2:0] REQ_RIGHT_DIR = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_ACCEL  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_ACCEL = 2'd1;
    localparam logic [1:0] CFG_INTERVAL    = 2'd2;

    localparam logic [7:0]  ACCEL_RESET    = 8'd5;
    localparam logic [15:0] INTERVAL_RESET = 16'd10;
    localparam logic [16:0] TICK_MAX       = 17'h1FFFF;

    // percent limits and raw speed limit
    localparam logic signed [15:0] PCT_MAX = 16'sd100;
    localparam logic signed [15:0] PCT_MIN = -16'sd100;
    localparam logic signed [15:0] RAW_MAX = 16'sd255;

    // reciprocal multipliers: mag*255/100 = (mag*1336965) >> 19,
    // speed*100/255 = (speed*1644900) >> 22, exact over the value ranges
    localparam logic [20:0] PCT_TO_SPD_MUL = 21'd1336965;
    localparam logic [20:0] SPD_TO_PCT_MUL = 21'd1644900;

    // what one request does to one channel
    typedef enum logic [2:0] {
        CH_NONE = 3'd0,
        CH_PCT  = 3'd1,
        CH_RAW  = 3'd2,
        CH_DIR  = 3'd3,
        CH_RAMP = 3'd4
    } t_chan_op;

    typedef struct packed {
        logic [7:0] speed;
        logic       fwd;
        logic       pending;
    } t_chan_state;

    typedef struct packed {
        logic [7:0] speed;
        logic       fwd;
        logic       pending;
        logic [7:0] pct;
    } t_chan_view;

    // percent magnitude (0..100) to speed (0..255), truncated
    function automatic logic [7:0] pct_to_speed(input logic [6:0] mag);
        logic [27:0] prod;
        prod = 28'(mag) * 28'(PCT_TO_SPD_MUL);
        return prod[26:19];
    endfunction

    // speed (0..255) to percent magnitude (0..100), truncated
    function automatic logic [7:0] speed_to_pct(input logic [7:0] speed);
        logic [28:0] prod;
        prod = 29'(speed) * 29'(SPD_TO_PCT_MUL);
        return {1'b0, prod[28:22]};
    endfunction

endpackage
`default_nettype wire

@@ src/dmpr_tick.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmpr_tick: update interval counter
// Counts tick requests with saturation and flags a ramp update once the
// count exceeds the interval; the count restarts at zero on an update.
// ----------------------------------------------------------------------------
module dmpr_tick
    import dmpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_tick,      // tick request retires this cycle
    input  wire logic [15:0] i_interval,
    output logic             o_update,    // ramp update for this tick
    output logic [16:0]      o_count
);

    logic [16:0] r_count;
    logic [16:0] n_count;
    logic [16:0] w_inc;

    // saturating increment and compare against the interval
    assign w_inc    = (r_count == TICK_MAX) ? r_count : r_count + 17'd1;
    assign o_update = i_tick && (w_inc > {1'b0, i_interval});

    always_comb begin
        n_count = r_count;
        if (i_tick) begin
            n_count = o_update ? '0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule
`default_nettype wire

@@ src/dmpr_chan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmpr_chan: one motor channel
// Holds speed, target and direction state, applies percent, raw and
// direction commands and the ramp step, and presents the state after the
// request together with its signed percent.
// ----------------------------------------------------------------------------
module dmpr_chan
    import dmpr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,       // request retires this cycle
    input  wire t_chan_op           i_op,
    input  wire logic signed [15:0] i_value,
    input  wire logic               i_flag,
    input  wire logic [7:0]         i_accel,
    output t_chan_state             o_cur,
    output t_chan_view              o_next
);

    logic [7:0] r_speed, n_speed;
    logic [7:0] r_target, n_target;
    logic       r_fwd, n_fwd;
    logic       r_tfwd, n_tfwd;
    logic       r_pend, n_pend;

    logic signed [7:0] w_pct_clamp;
    logic [7:0]        w_pct_abs;
    logic              w_pct_neg;
    logic [7:0]        w_raw;
    logic [8:0]        w_sum;
    logic [7:0]        w_dec;
    logic [7:0]        w_mag_pct;

    // command value clamping
    always_comb begin
        if (i_value > PCT_MAX) begin
            w_pct_clamp = 8'(PCT_MAX);
        end else if (i_value < PCT_MIN) begin
            w_pct_clamp = 8'(PCT_MIN);
        end else begin
            w_pct_clamp = i_value[7:0];
        end
    end

    assign w_pct_neg = w_pct_clamp[7];
    assign w_pct_abs = w_pct_neg ? 8'd0 - w_pct_clamp : w_pct_clamp;

    always_comb begin
        if (i_value < 16'sd0) begin
            w_raw = '0;
        end else if (i_value > RAW_MAX) begin
            w_raw = 8'hFF;
        end else begin
            w_raw = i_value[7:0];
        end
    end

    // ramp step candidates
    assign w_sum = {1'b0, r_speed} + {1'b0, i_accel};
    assign w_dec = (r_speed > i_accel) ? r_speed - i_accel : 8'd0;

    // next state
    always_comb begin
        n_speed  = r_speed;
        n_target = r_target;
        n_fwd    = r_fwd;
        n_tfwd   = r_tfwd;
        n_pend   = r_pend;
        case (i_op)
            CH_PCT: begin
                n_tfwd   = !w_pct_neg;
                n_target = pct_to_speed(w_pct_abs[6:0]);
                n_pend   = (r_fwd != !w_pct_neg);
            end
            CH_RAW: begin
                n_target = w_raw;
            end
            CH_DIR: begin
                n_fwd = i_flag;
            end
            CH_RAMP: begin
                if (r_pend) begin
                    // slow to a stop, then flip
                    if (r_speed != '0) begin
                        n_speed = w_dec;
                    end else begin
                        n_fwd  = r_tfwd;
                        n_pend = 1'b0;
                    end
                end else if (r_speed < r_target) begin
                    n_speed = (w_sum < {1'b0, r_target}) ? w_sum[7:0] : r_target;
                end else if (r_speed > r_target) begin
                    n_speed = (w_dec > r_target) ? w_dec : r_target;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= '0;
            r_target <= '0;
            r_fwd    <= 1'b1;
            r_tfwd   <= 1'b1;
            r_pend   <= 1'b0;
        end else if (i_en) begin
            r_speed  <= n_speed;
            r_target <= n_target;
            r_fwd    <= n_fwd;
            r_tfwd   <= n_tfwd;
            r_pend   <= n_pend;
        end
    end

    // view after the request
    assign w_mag_pct = speed_to_pct(n_speed);

    assign o_next.speed   = n_speed;
    assign o_next.fwd     = n_fwd;
    assign o_next.pending = n_pend;
    assign o_next.pct     = n_fwd ? w_mag_pct : 8'd0 - w_mag_pct;

    assign o_cur.speed   = r_speed;
    assign o_cur.fwd     = r_fwd;
    assign o_cur.pending = r_pend;

endmodule
`default_nettype wire

@@ src/dual_motor_pwm_ramp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A request accepted at the slave side passes the input register, then the
// result register, which presents its result to the master side.
// Throughput: one request per cycle; a result held by the master side holds
// the input register, and both move again in the cycle the result is taken.
// Reset (synchronous, active low): speeds and targets zero, directions
// forward, no reversal pending, tick count zero, accel 5, interval 10.
// ----------------------------------------------------------------------------
// dual_motor_pwm_ramp: two-channel PWM ramp generator
// Takes tick and command requests, ramps both channels toward their targets
// with reversal through zero, and returns one status result per request.
// ----------------------------------------------------------------------------
module dual_motor_pwm_ramp
    import dmpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // command_value[15:0], forward_flag[16], zero
    input  wire logic [2:0]  s_axis_tuser,   // req_type[2:0]
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // left_duty[7:0], right_duty[15:8], left_dir_out[16], right_dir_out[17],
    // left_signed_percent[25:18], right_signed_percent[33:26],
    // left_reversal_pending[34], right_reversal_pending[35],
    // ramp_updated[36], zero
    output logic [39:0]      m_axis_tdata,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    // configuration registers
    logic [7:0]  r_left_accel;
    logic [7:0]  r_right_accel;
    logic [15:0] r_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_accel  <= ACCEL_RESET;
            r_right_accel <= ACCEL_RESET;
            r_interval    <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT_ACCEL:  r_left_accel  <= i_cfg_data[7:0];
                CFG_RIGHT_ACCEL: r_right_accel <= i_cfg_data[7:0];
                CFG_INTERVAL:    r_interval    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    logic               r_in_vld;
    logic [2:0]         r_in_req;
    logic signed [15:0] r_in_val;
    logic               r_in_fwd;
    logic               w_adv;
    logic               w_s_acc;

    assign w_adv         = r_in_vld && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_s_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_req <= s_axis_tuser;
            r_in_val <= s_axis_tdata[15:0];
            r_in_fwd <= s_axis_tdata[16];
        end
    end

    // tick counter
    logic        w_tick;
    logic        w_upd;
    logic [16:0] w_count;

    assign w_tick = w_adv && (r_in_req == REQ_TICK);

    dmpr_tick u_tick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_tick),
        .i_interval (r_interval),
        .o_update   (w_upd),
        .o_count    (w_count)
    );

    // request decode per channel
    t_chan_op w_left_op;
    t_chan_op w_right_op;

    always_comb begin
        w_left_op  = CH_NONE;
        w_right_op = CH_NONE;
        case (r_in_req)
            REQ_TICK: begin
                if (w_upd) begin
                    w_left_op  = CH_RAMP;
                    w_right_op = CH_RAMP;
                end
            end
            REQ_LEFT_PCT:  w_left_op  = CH_PCT;
            REQ_RIGHT_PCT: w_right_op = CH_PCT;
            REQ_LEFT_RAW:  w_left_op  = CH_RAW;
            REQ_RIGHT_RAW: w_right_op = CH_RAW;
            REQ_LEFT_DIR:  w_left_op  = CH_DIR;
            REQ_RIGHT_DIR: w_right_op = CH_DIR;
            default: begin
            end
        endcase
    end

    // channels
    t_chan_state w_left_cur, w_right_cur;
    t_chan_view  w_left_nxt, w_right_nxt;

    dmpr_chan u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_op    (w_left_op),
        .i_value (r_in_val),
        .i_flag  (r_in_fwd),
        .i_accel (r_left_accel),
        .o_cur   (w_left_cur),
        .o_next  (w_left_nxt)
    );

    dmpr_chan u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_op    (w_right_op),
        .i_value (r_in_val),
        .i_flag  (r_in_fwd),
        .i_accel (r_right_accel),
        .o_cur   (w_right_cur),
        .o_next  (w_right_nxt)
    );

    // result register
    logic        r_out_vld;
    logic [39:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {3'b000, w_upd,
                           w_right_nxt.pending, w_left_nxt.pending,
                           w_right_nxt.pct, w_left_nxt.pct,
                           w_right_nxt.fwd, w_left_nxt.fwd,
                           w_right_nxt.speed, w_left_nxt.speed};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_upd_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_upd) |=> (w_count == '0))
        else $error("tick count not restarted after ramp update");

    a_left_pend_no_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_left_cur.pending && (w_left_cur.speed != '0))
        |=> (w_left_cur.speed <= $past(w_left_cur.speed)))
        else $error("left speed rose during pending reversal");

    a_right_pend_no_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_right_cur.pending && (w_right_cur.speed != '0))
        |=> (w_right_cur.speed <= $past(w_right_cur.speed)))
        else $error("right speed rose during pending reversal");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_vld && r_out_vld && !m_axis_tready))
        else $error("slave side stalled without a full pipeline");

endmodule
`default_nettype wire

@@ dv/dual_motor_pwm_ramp_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_pwm_ramp_tb: self-checking bench for the two-channel PWM ramp
// Drives tick and command requests through the slave stream and keeps its own
// model of both channels. Every status result is checked field by field.
// Runs a directed set of corner cases, then random phases under several
// register settings, with random gaps on the slave side and random back-pressure on the master side.
// ----------------------------------------------------------------------------
module dual_motor_pwm_ramp_tb;
    import dmpr_pkg::*;

    localparam logic [2:0] REQ_UNUSED   = 3'd7;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam int         IDLE_PCT     = 14;
    localparam int         RX_HOLD      = 80;
    localparam int         WATCHDOG_MAX = 1000;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] value;
        logic               fwd;
    } motor_req_t;

    typedef struct packed {
        logic [7:0] speed;
        logic [7:0] target;
        logic       fwd;
        logic       target_fwd;
        logic       pending;
    } motor_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata   = '0;   // command_value[15:0], forward_flag[16], zero
    logic [2:0]  s_axis_tuser   = '0;   // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    // left_duty[7:0], right_duty[15:8], left_dir_out[16], right_dir_out[17],
    // left_signed_percent[25:18], right_signed_percent[33:26],
    // left_reversal_pending[34], right_reversal_pending[35], ramp_updated[36]
    logic [39:0] m_axis_tdata;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_idx      = '0;
    logic [15:0] i_cfg_data     = '0;

    dual_motor_pwm_ramp i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // model state: channel 0 is left, channel 1 is right
    motor_t      mot [2];
    logic [7:0]  accel_m [2];
    logic [15:0] interval_m;
    logic [16:0] tick_cnt;

    motor_req_t  cmd_q [$];      // requests waiting for the driver
    logic [39:0] status_q [$];   // predicted status, oldest first
    motor_req_t  nxt_req;

    logic        in_taken      = 1'b0;
    logic        no_idle       = 1'b0;
    logic        rx_block_req  = 1'b0;
    logic        rx_block_done = 1'b0;
    int          rx_hold_cnt   = 0;
    int          stall_cycles  = 0;
    int          fail_cnt      = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // channel model
    // ------------------------------------------------------------------
    function automatic motor_t ramp_motor(motor_t m, logic [7:0] a);
        int s;
        if (m.pending) begin
            // brake to zero first, flip only once stopped
            if (m.speed != 8'd0) begin
                m.speed = (m.speed > a) ? m.speed - a : 8'd0;
            end else begin
                m.fwd     = m.target_fwd;
                m.pending = 1'b0;
            end
        end else if (m.speed < m.target) begin
            s = m.speed + a;
            m.speed = (s < m.target) ? s[7:0] : m.target;
        end else if (m.speed > m.target) begin
            s = (m.speed > a) ? m.speed - a : 0;
            m.speed = (s > m.target) ? s[7:0] : m.target;
        end
        return m;
    endfunction

    function automatic motor_t apply_pct(motor_t m, logic signed [15:0] v);
        int p;
        int mag;
        p = v;
        if (p > 100) p = 100;
        if (p < -100) p = -100;
        mag = (p < 0) ? -p : p;
        m.target_fwd = (p >= 0);
        m.target     = 8'((mag * 255) / 100);
        m.pending    = (m.fwd != m.target_fwd);
        return m;
    endfunction

    function automatic logic [7:0] clamp_raw(logic signed [15:0] v);
        int r;
        r = v;
        if (r < 0) r = 0;
        if (r > 255) r = 255;
        return 8'(r);
    endfunction

    function automatic logic [7:0] pct_of(motor_t m);
        logic [31:0] p;
        p = (m.speed * 100) / 255;
        if (!m.fwd) p = -p;
        return p[7:0];
    endfunction

    // advance the model by one request, return the expected status word
    function automatic logic [39:0] predict_status(logic [2:0] kind, logic signed [15:0] v,
                                                   logic f);
        logic upd;
        upd = 1'b0;
        case (kind)
            REQ_TICK: begin
                if (tick_cnt < TICK_MAX) tick_cnt = tick_cnt + 17'd1;
                if (tick_cnt > {1'b0, interval_m}) begin
                    tick_cnt = '0;
                    mot[0]   = ramp_motor(mot[0], accel_m[0]);
                    mot[1]   = ramp_motor(mot[1], accel_m[1]);
                    upd      = 1'b1;
                end
            end
            REQ_LEFT_PCT:  mot[0] = apply_pct(mot[0], v);
            REQ_RIGHT_PCT: mot[1] = apply_pct(mot[1], v);
            REQ_LEFT_RAW:  mot[0].target = clamp_raw(v);
            REQ_RIGHT_RAW: mot[1].target = clamp_raw(v);
            REQ_LEFT_DIR:  mot[0].fwd = f;
            REQ_RIGHT_DIR: mot[1].fwd = f;
            default: ;
        endcase
        return {3'b000, upd, mot[1].pending, mot[0].pending, pct_of(mot[1]), pct_of(mot[0]),
                mot[1].fwd, mot[0].fwd, mot[1].speed, mot[0].speed};
    endfunction

    task automatic cmp_field(string name, logic [7:0] e, logic [7:0] a);
        if (e !== a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            fail_cnt++;
        end
    endtask

    task automatic check_status(logic [39:0] exp, logic [39:0] act);
        cmp_field("left_duty",              exp[7:0],   act[7:0]);
        cmp_field("right_duty",             exp[15:8],  act[15:8]);
        cmp_field("left_dir_out",           exp[16],    act[16]);
        cmp_field("right_dir_out",          exp[17],    act[17]);
        cmp_field("left_signed_percent",    exp[25:18], act[25:18]);
        cmp_field("right_signed_percent",   exp[33:26], act[33:26]);
        cmp_field("left_reversal_pending",  exp[34],    act[34]);
        cmp_field("right_reversal_pending", exp[35],    act[35]);
        cmp_field("ramp_updated",           exp[36],    act[36]);
    endtask

    // ------------------------------------------------------------------
    // request driver: next request goes out once the current one is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (cmd_q.size() != 0 && (no_idle || $urandom_range(99, 0) >= IDLE_PCT)) begin
                nxt_req = cmd_q.pop_front();
                s_axis_tuser  <= nxt_req.kind;
                s_axis_tdata  <= {7'b0, nxt_req.fwd, nxt_req.value};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // status sink: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_cnt != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_cnt   <= rx_hold_cnt - 1;
        end else if (rx_block_req && !rx_block_done) begin
            m_axis_tready <= 1'b0;
            rx_hold_cnt   <= RX_HOLD;
            rx_block_done <= 1'b1;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // monitor: check results against the model, predict accepted requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_q.size() == 0) begin
                    $error("status result with no request outstanding");
                    fail_cnt++;
                end else begin
                    check_status(status_q.pop_front(), m_axis_tdata);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                status_q.push_back(predict_status(s_axis_tuser, s_axis_tdata[15:0],
                                                  s_axis_tdata[16]));
            end
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_LEFT_ACCEL:  accel_m[0] = val[7:0];
            CFG_RIGHT_ACCEL: accel_m[1] = val[7:0];
            CFG_INTERVAL:    interval_m = val;
            default: ;
        endcase
    endtask

    task automatic add_req(logic [2:0] kind, logic signed [15:0] v, logic f);
        cmd_q.push_back('{kind, v, f});
    endtask

    // wait until every request is out and every status has come back
    task automatic drain();
        while (cmd_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(3, 0))
            0: return 16'($urandom);
            1: return 16'($urandom_range(240, 0)) - 16'sd120;
            2: return 16'($urandom_range(300, 0)) - 16'sd20;
            default: begin
                case ($urandom_range(5, 0))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sd0;
                    3: return 16'sd100;
                    4: return -16'sd100;
                    default: return 16'sd255;
                endcase
            end
        endcase
    endfunction

    // about half ticks so the ramps keep moving, commands in between
    task automatic queue_random(int n);
        int r;
        logic [2:0] kind;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99, 0);
            if (r < 50)      kind = REQ_TICK;
            else if (r < 53) kind = REQ_UNUSED;
            else             kind = 3'($urandom_range(6, 1));
            add_req(kind, pick_value(), 1'($urandom));
        end
    endtask

    task automatic random_phase(logic [7:0] la, logic [7:0] ra, logic [15:0] intv, int n,
                                logic quiet, logic rx_block);
        drain();
        write_reg(CFG_LEFT_ACCEL, {8'd0, la});
        write_reg(CFG_RIGHT_ACCEL, {8'd0, ra});
        write_reg(CFG_INTERVAL, intv);
        @(posedge i_clk);
        no_idle      = quiet;
        rx_block_req = rx_block;
        queue_random(n);
    endtask

    initial begin
        for (int c = 0; c < 2; c++) begin
            mot[c]     = '{speed: 8'd0, target: 8'd0, fwd: 1'b1, target_fwd: 1'b1,
                           pending: 1'b0};
            accel_m[c] = ACCEL_RESET;
        end
        interval_m = INTERVAL_RESET;
        tick_cnt   = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every tick updates, left ramps by 60, right frozen
        write_reg(CFG_INTERVAL, 16'd0);
        write_reg(CFG_LEFT_ACCEL, 16'd60);
        write_reg(CFG_RIGHT_ACCEL, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);     // unmapped index, must be ignored
        @(posedge i_clk);
        add_req(REQ_TICK,      16'sh7FFF, 1'b1);
        add_req(REQ_LEFT_PCT,  16'sh7FFF, 1'b0);   // clamps to 100
        add_req(REQ_RIGHT_RAW, 16'sd300,  1'b1);   // clamps to 255
        add_req(REQ_TICK,      16'sd0,    1'b0);
        add_req(REQ_TICK,      16'sd0,    1'b0);
        add_req(REQ_LEFT_PCT,  16'sh8000, 1'b1);   // clamps to -100, reversal pending
        add_req(REQ_TICK,      16'sd0,    1'b0);
        add_req(REQ_TICK,      16'sd0,    1'b0);   // reaches zero
        add_req(REQ_TICK,      16'sd0,    1'b0);   // direction flips
        add_req(REQ_TICK,      16'sd0,    1'b0);   // running in reverse
        add_req(REQ_LEFT_DIR,  -16'sd1,   1'b1);   // direct flip
        add_req(REQ_LEFT_PCT,  16'sd0,    1'b0);
        add_req(REQ_TICK,      16'sd0,    1'b0);
        add_req(REQ_RIGHT_PCT, -16'sd100, 1'b1);   // pending at zero speed, zero accel
        add_req(REQ_TICK,      16'sd0,    1'b0);
        add_req(REQ_LEFT_RAW,  -16'sd5,   1'b0);   // clamps to 0
        add_req(REQ_RIGHT_RAW, 16'sh8000, 1'b0);
        add_req(REQ_LEFT_RAW,  16'sd255,  1'b1);
        add_req(REQ_RIGHT_DIR, 16'sd0,    1'b0);
        add_req(REQ_UNUSED,    16'sh8000, 1'b1);   // unused code, status only
        add_req(REQ_LEFT_PCT,  16'sd50,   1'b1);
        add_req(REQ_TICK,      16'sd0,    1'b0);

        // zero accel while a reversal is pending at zero speed
        drain();
        write_reg(CFG_RIGHT_ACCEL, 16'd255);
        @(posedge i_clk);
        add_req(REQ_RIGHT_PCT, 16'sd100, 1'b0);
        add_req(REQ_TICK,      16'sd0,   1'b0);
        drain();
        write_reg(CFG_RIGHT_ACCEL, 16'd0);
        @(posedge i_clk);
        add_req(REQ_RIGHT_PCT, -16'sd50, 1'b0);
        add_req(REQ_TICK,      16'sd0,   1'b0);   // direction flips

        // longest interval: ticks only count
        drain();
        write_reg(CFG_INTERVAL, 16'hFFFF);
        @(posedge i_clk);
        add_req(REQ_TICK, 16'sd0, 1'b1);
        add_req(REQ_TICK, 16'sd0, 1'b0);

        // random phases over several register settings
        random_phase(8'd5,   8'd5,   16'd10, 120, 1'b0, 1'b0);
        random_phase(8'd255, 8'd255, 16'd0,  120, 1'b0, 1'b0);
        random_phase(8'd0,   8'd1,   16'd2,  120, 1'b0, 1'b0);
        random_phase(8'd17,  8'd200, 16'd1,  120, 1'b1, 1'b0);
        random_phase(8'($urandom), 8'($urandom), 16'($urandom_range(4, 0)), 120, 1'b0, 1'b1);
        random_phase(8'd1,   8'd0,   16'd0,  110, 1'b0, 1'b0);
        random_phase(8'($urandom), 8'($urandom), 16'($urandom_range(20, 0)), 120, 1'b0, 1'b0);
        random_phase(8'd128, 8'd64,  16'd3,  120, 1'b0, 1'b0);

        drain();
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
